>>> rtl/gakc_pkg.sv
// Shared constants, types and arithmetic helpers for the golden-angle k-space coordinate unit.
package gakc_pkg;

   localparam int SPOKE_BITS     = 16;
   localparam int SAMPLE_BITS    = 12;
   localparam int CFG_N_BITS     = 13;
   localparam int MAX_SAMPLES    = 4096;
   localparam int MIN_SAMPLES    = 2;
   localparam int N_BITS         = $clog2(MAX_SAMPLES + 1);
   localparam int RESET_SAMPLES  = 256;
   localparam int DEF_ANGLE_BITS = 24;
   localparam int DEF_COORD_BITS = 16;

   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic REG_SAMPLES = 1'b0;
   localparam logic REG_THREE_D = 1'b1;

   localparam int DEC_BITS = 50;
   localparam logic [DEC_BITS-1:0] DEC_ONE  = 50'd1000000000000000;
   localparam logic [DEC_BITS-1:0] GA2D_DEC = 50'd309016994374947;
   localparam logic [DEC_BITS-1:0] GM1_DEC  = 50'd465571231876768;
   localparam logic [DEC_BITS-1:0] GM2_DEC  = 50'd682327803828020;

   localparam int RADIUS_STEPS = 30;
   localparam int RADIUS_W     = RADIUS_STEPS + 1;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 32;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam int SQRT_STEPS = 32;
   localparam int SQRT_W     = 64;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } cordic_type;

   function automatic logic [DEC_BITS-1:0] mod_add(input logic [DEC_BITS-1:0] a,
                                                   input logic [DEC_BITS-1:0] b);
      logic [DEC_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, DEC_ONE}) s = s - {1'b0, DEC_ONE};
      return s[DEC_BITS-1:0];
   endfunction

   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
      logic signed [CORDIC_W-1:0] a;
      case (i)
         0:  a = 32'sh20000000;
         1:  a = 32'sh12E4051D;
         2:  a = 32'sh09FB385B;
         3:  a = 32'sh051111D4;
         4:  a = 32'sh028B0D43;
         5:  a = 32'sh0145D7E1;
         6:  a = 32'sh00A2F61E;
         7:  a = 32'sh00517C55;
         8:  a = 32'sh0028BE53;
         9:  a = 32'sh00145F2E;
         10: a = 32'sh000A2F98;
         11: a = 32'sh000517CC;
         12: a = 32'sh00028BE6;
         13: a = 32'sh000145F3;
         14: a = 32'sh0000A2F9;
         15: a = 32'sh0000517C;
         16: a = 32'sh000028BE;
         17: a = 32'sh0000145F;
         18: a = 32'sh00000A2F;
         19: a = 32'sh00000517;
         20: a = 32'sh0000028B;
         21: a = 32'sh00000145;
         22: a = 32'sh000000A2;
         23: a = 32'sh00000051;
         24: a = 32'sh00000028;
         25: a = 32'sh00000014;
         26: a = 32'sh0000000A;
         27: a = 32'sh00000005;
         28: a = 32'sh00000002;
         29: a = 32'sh00000001;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/gakc_delay.sv
// Enabled shift line that keeps side data in step with the arithmetic pipeline.
module gakc_delay
   import gakc_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) pipe_ff[k] <= pipe_ff[k-1];
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

>>> rtl/gakc_frac.sv
// Pipelined exact fractional part of spoke times a decimal golden constant, in turns.
module gakc_frac
   import gakc_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DEC_BITS-1:0]   g,
   input  logic [SPOKE_BITS-1:0] spoke,
   output logic [ANGLE_BITS-1:0] frac
);

   localparam int NS = SPOKE_BITS + ANGLE_BITS;

   logic [DEC_BITS-1:0]   rem_ff [NS-1];
   logic [DEC_BITS-1:0]   rem_in [NS-1];
   logic [SPOKE_BITS-1:0] spk_ff [SPOKE_BITS-1];
   logic [SPOKE_BITS-1:0] spk_in [SPOKE_BITS-1];
   logic [ANGLE_BITS-1:0] q_ff   [ANGLE_BITS];
   logic [ANGLE_BITS-1:0] q_in   [ANGLE_BITS];

   function automatic logic [DEC_BITS-1:0] horner(input logic [DEC_BITS-1:0] r,
                                                  input logic b,
                                                  input logic [DEC_BITS-1:0] gv);
      logic [DEC_BITS-1:0] t;
      t = mod_add(r, r);
      if (b) t = mod_add(t, gv);
      return t;
   endfunction

   function automatic logic [DEC_BITS:0] restore(input logic [DEC_BITS-1:0] r);
      logic [DEC_BITS:0] d;
      logic [DEC_BITS:0] s;
      d = {r, 1'b0};
      s = d - {1'b0, DEC_ONE};
      if (d >= {1'b0, DEC_ONE}) return {1'b1, s[DEC_BITS-1:0]};
      return {1'b0, d[DEC_BITS-1:0]};
   endfunction

   always_comb begin
      logic [DEC_BITS:0] rs;
      rem_in[0] = spoke[SPOKE_BITS-1] ? g : '0;
      spk_in[0] = spoke;
      for (int k = 1; k < SPOKE_BITS; k++) begin
         rem_in[k] = horner(rem_ff[k-1], spk_ff[k-1][SPOKE_BITS-1-k], g);
      end
      for (int k = 1; k < SPOKE_BITS - 1; k++) spk_in[k] = spk_ff[k-1];
      rs = restore(rem_ff[SPOKE_BITS-1]);
      rem_in[SPOKE_BITS] = rs[DEC_BITS-1:0];
      q_in[0] = {{(ANGLE_BITS-1){1'b0}}, rs[DEC_BITS]};
      for (int j = 1; j < ANGLE_BITS - 1; j++) begin
         rs = restore(rem_ff[SPOKE_BITS+j-1]);
         rem_in[SPOKE_BITS+j] = rs[DEC_BITS-1:0];
         q_in[j] = {q_ff[j-1][ANGLE_BITS-2:0], rs[DEC_BITS]};
      end
      rs = restore(rem_ff[NS-2]);
      q_in[ANGLE_BITS-1] = {q_ff[ANGLE_BITS-2][ANGLE_BITS-2:0], rs[DEC_BITS]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS - 1; k++) rem_ff[k] <= rem_in[k];
         for (int k = 0; k < SPOKE_BITS - 1; k++) spk_ff[k] <= spk_in[k];
         for (int j = 0; j < ANGLE_BITS; j++) q_ff[j] <= q_in[j];
      end
   end

   assign frac = q_ff[ANGLE_BITS-1];

endmodule

>>> rtl/gakc_radius.sv
// Pipelined restoring divider giving the rounded radius magnitude and its sign.
module gakc_radius
   import gakc_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic [SAMPLE_BITS-1:0]  sample,
   input  logic [N_BITS-1:0]       n,
   output logic [RADIUS_STEPS-1:0] quo,
   output logic                    neg
);

   localparam int RS = RADIUS_STEPS / 2;
   localparam int TW = N_BITS + 1;

   logic [N_BITS-1:0]       rem_ff [RS-1];
   logic [N_BITS-1:0]       rem_in [RS-1];
   logic [RADIUS_STEPS-1:0] dv_ff  [RS-1];
   logic [RADIUS_STEPS-1:0] dv_in  [RS-1];
   logic [RADIUS_STEPS-1:0] q_ff   [RS];
   logic [RADIUS_STEPS-1:0] q_in   [RS];
   logic                    neg_ff [RS];
   logic                    neg_in [RS];

   function automatic logic [N_BITS:0] div_step(input logic [N_BITS-1:0] r,
                                                input logic b,
                                                input logic [N_BITS-1:0] nv);
      logic [N_BITS:0] t;
      logic [N_BITS:0] s;
      t = {r, b};
      s = t - {1'b0, nv};
      if (t >= {1'b0, nv}) return {1'b1, s[N_BITS-1:0]};
      return {1'b0, t[N_BITS-1:0]};
   endfunction

   always_comb begin
      logic [TW-1:0]           twice;
      logic [TW-1:0]           magw;
      logic [N_BITS-1:0]       mag;
      logic [RADIUS_STEPS-1:0] dv0;
      logic [N_BITS:0]         s1;
      logic [N_BITS:0]         s2;
      twice = TW'(sample) << 1;
      magw  = (twice >= TW'(n)) ? twice - TW'(n) : TW'(n) - twice;
      mag   = magw[N_BITS-1:0];
      dv0   = {mag[0], (RADIUS_STEPS-1)'(n >> 1)};
      s1 = div_step(mag >> 1, dv0[RADIUS_STEPS-1], n);
      s2 = div_step(s1[N_BITS-1:0], dv0[RADIUS_STEPS-2], n);
      rem_in[0] = s2[N_BITS-1:0];
      dv_in[0]  = dv0 << 2;
      q_in[0]   = {{(RADIUS_STEPS-2){1'b0}}, s1[N_BITS], s2[N_BITS]};
      neg_in[0] = twice < TW'(n);
      for (int s = 1; s < RS - 1; s++) begin
         s1 = div_step(rem_ff[s-1], dv_ff[s-1][RADIUS_STEPS-1], n);
         s2 = div_step(s1[N_BITS-1:0], dv_ff[s-1][RADIUS_STEPS-2], n);
         rem_in[s] = s2[N_BITS-1:0];
         dv_in[s]  = dv_ff[s-1] << 2;
         q_in[s]   = {q_ff[s-1][RADIUS_STEPS-3:0], s1[N_BITS], s2[N_BITS]};
         neg_in[s] = neg_ff[s-1];
      end
      s1 = div_step(rem_ff[RS-2], dv_ff[RS-2][RADIUS_STEPS-1], n);
      s2 = div_step(s1[N_BITS-1:0], dv_ff[RS-2][RADIUS_STEPS-2], n);
      q_in[RS-1]   = {q_ff[RS-2][RADIUS_STEPS-3:0], s1[N_BITS], s2[N_BITS]};
      neg_in[RS-1] = neg_ff[RS-2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < RS - 1; s++) begin
            rem_ff[s] <= rem_in[s];
            dv_ff[s]  <= dv_in[s];
         end
         for (int s = 0; s < RS; s++) begin
            q_ff[s]   <= q_in[s];
            neg_ff[s] <= neg_in[s];
         end
      end
   end

   assign quo = q_ff[RS-1];
   assign neg = neg_ff[RS-1];

endmodule

>>> rtl/gakc_cordic.sv
// Pipelined CORDIC rotator giving cosine and sine of a turn fraction.
module gakc_cordic
   import gakc_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ANGLE_BITS-1:0]      angle,
   output logic signed [CORDIC_W-1:0] cos_o,
   output logic signed [CORDIC_W-1:0] sin_o
);

   localparam int CS = CORDIC_STEPS / 2;
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   cordic_type v_ff    [CS-1];
   cordic_type v_in    [CS-1];
   logic [1:0] quad_ff [CS-1];
   logic [1:0] quad_in [CS-1];
   logic signed [CORDIC_W-1:0] c_ff, s_ff, c_in, s_in;

   function automatic cordic_type rot(input cordic_type v, input int i);
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      cordic_type r;
      x = v.x;
      y = v.y;
      z = v.z;
      if (!z[CORDIC_W-1]) begin
         r.x = x - (y >>> i);
         r.y = y + (x >>> i);
         r.z = z - atan_turn(i);
      end else begin
         r.x = x + (y >>> i);
         r.y = y - (x >>> i);
         r.z = z + atan_turn(i);
      end
      return r;
   endfunction

   always_comb begin
      logic [31:0] a32;
      cordic_type  v0;
      cordic_type  vl;
      a32  = 32'(angle) << (32 - ANGLE_BITS);
      v0.x = CORDIC_GAIN;
      v0.y = '0;
      v0.z = {2'b00, a32[29:0]};
      v_in[0]    = rot(rot(v0, 0), 1);
      quad_in[0] = a32[31:30];
      for (int s = 1; s < CS - 1; s++) begin
         v_in[s]    = rot(rot(v_ff[s-1], 2 * s), 2 * s + 1);
         quad_in[s] = quad_ff[s-1];
      end
      vl = rot(rot(v_ff[CS-2], 2 * CS - 2), 2 * CS - 1);
      case (quad_ff[CS-2])
         QUAD_0: begin
            c_in = vl.x;
            s_in = vl.y;
         end
         QUAD_1: begin
            c_in = -vl.y;
            s_in = vl.x;
         end
         QUAD_2: begin
            c_in = -vl.x;
            s_in = -vl.y;
         end
         QUAD_3: begin
            c_in = vl.y;
            s_in = -vl.x;
         end
         default: begin
            c_in = vl.x;
            s_in = vl.y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < CS - 1; s++) begin
            v_ff[s]    <= v_in[s];
            quad_ff[s] <= quad_in[s];
         end
         c_ff <= c_in;
         s_ff <= s_in;
      end
   end

   assign cos_o = c_ff;
   assign sin_o = s_ff;

endmodule

>>> rtl/gakc_isqrt.sv
// Pipelined integer square root of one minus the squared polar fraction.
module gakc_isqrt
   import gakc_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] f31,
   output logic [31:0] root
);

   localparam int SQ = SQRT_STEPS / 2;

   typedef struct packed {
      logic [SQRT_W-1:0] d;
      logic [SQRT_W-1:0] res;
   } sqrt_type;

   logic [SQRT_W-1:0] d0_ff;
   logic [SQRT_W-1:0] d0_in;
   sqrt_type          st_ff [SQ];
   sqrt_type          st_in [SQ];

   function automatic sqrt_type sq_step(input sqrt_type v, input int j);
      logic [SQRT_W-1:0] b;
      logic [SQRT_W-1:0] t;
      sqrt_type r;
      b = 64'd1 << (62 - 2 * j);
      t = v.res + b;
      if (v.d >= t) begin
         r.d   = v.d - t;
         r.res = (v.res >> 1) + b;
      end else begin
         r.d   = v.d;
         r.res = v.res >> 1;
      end
      return r;
   endfunction

   always_comb begin
      logic [61:0] sq;
      sqrt_type    v0;
      sq    = f31 * f31;
      d0_in = (64'd1 << 62) - {2'b00, sq};
      v0.d   = d0_ff;
      v0.res = '0;
      st_in[0] = sq_step(sq_step(v0, 0), 1);
      for (int s = 1; s < SQ; s++) begin
         st_in[s] = sq_step(sq_step(st_ff[s-1], 2 * s), 2 * s + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff <= d0_in;
         for (int s = 0; s < SQ; s++) st_ff[s] <= st_in[s];
      end
   end

   assign root = st_ff[SQ-1].res[31:0];

endmodule

>>> rtl/golden_angle_radial_kspace_coords_unit.sv
// Top level of the golden-angle radial k-space coordinate unit.
// Each beat on the req_ channel carries a spoke index and a sample index; each
// beat on the rsp_ channel carries one coordinate (x, y, z in signed Q0.15 at
// the default width) and an index error flag. Results leave in request order.
// A beat is taken on a rising edge with valid high and stall low.
// The golden fraction pipeline (16 + ANGLE_BITS stages) is followed by the
// square root, the polar multiply, the coordinate multiply and the rounding
// stage. Throughput is one beat per cycle while the receiver does not stall;
// every unit is fully pipelined.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall rises, so nothing is lost or repeated.
// Reset empties the pipeline and sets samples_per_spoke to 256, the mode to 2D.
// The APB-style port holds samples_per_spoke at byte address 0, the 3D mode bit
// at address 4; the user must write it only while the unit is idle, as the block does not enforce it.
module golden_angle_radial_kspace_coords_unit
   import gakc_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [SPOKE_BITS-1:0]        req_spoke_index,
   input  logic [SAMPLE_BITS-1:0]       req_sample_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_coord_x,
   output logic signed [COORD_BITS-1:0] rsp_coord_y,
   output logic signed [COORD_BITS-1:0] rsp_coord_z,
   output logic                         rsp_index_error,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ADDR_BITS-1:0]         paddr,
   input  logic [DATA_BITS-1:0]         pwdata,
   output logic [DATA_BITS-1:0]         prdata,
   output logic                         pready
);

   localparam int LF  = SPOKE_BITS + ANGLE_BITS;
   localparam int LAT = LF + 20;
   localparam int XS  = 61 - COORD_BITS;
   localparam int ZS  = 62 - COORD_BITS;
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (COORD_BITS - 1));

   logic [CFG_N_BITS-1:0] n_cfg_ff;
   logic                  three_d_ff;
   logic [LAT-1:0]        vld_ff;
   logic                  en;
   logic                  cfg_wr;
   logic                  reg_idx;
   logic [N_BITS-1:0]     n_eff;
   logic                  err_now;
   logic [DEC_BITS-1:0]   g_a;

   logic [ANGLE_BITS-1:0]       frac_a, frac_b;
   logic [RADIUS_STEPS-1:0]     quo;
   logic                        neg;
   logic signed [RADIUS_W-1:0]  r_div, r_a, r_b_ff;
   logic signed [CORDIC_W-1:0]  cos_c, sin_c, c_d, s_d;
   logic [2*CORDIC_W-1:0]       cs_d;
   logic [31:0]                 a32b;
   logic [30:0]                 f31, f31_d;
   logic [31:0]                 root;
   logic signed [32:0]          root_s;
   logic signed [63:0]          rt_prod, rt_sh;
   logic signed [31:0]          t_ff, m;
   logic signed [63:0]          px_ff, py_ff, pz_ff;
   logic                        err_d;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic                        err_ff;

   function automatic logic [COORD_BITS-1:0] round_sat(input logic signed [63:0] v,
                                                       input int sh);
      logic signed [63:0] q;
      q = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      return q[COORD_BITS-1:0];
   endfunction

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign reg_idx = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         n_cfg_ff   <= CFG_N_BITS'(RESET_SAMPLES);
         three_d_ff <= 1'b0;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_SAMPLES: n_cfg_ff   <= pwdata[CFG_N_BITS-1:0];
            REG_THREE_D: three_d_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SAMPLES: prdata = DATA_BITS'(n_cfg_ff);
         REG_THREE_D: prdata = DATA_BITS'(three_d_ff);
         default:     prdata = '0;
      endcase
   end

   always_comb begin
      if (int'(n_cfg_ff) > MAX_SAMPLES) n_eff = N_BITS'(MAX_SAMPLES);
      else if (int'(n_cfg_ff) < MIN_SAMPLES) n_eff = N_BITS'(MIN_SAMPLES);
      else n_eff = N_BITS'(n_cfg_ff);
   end

   assign err_now   = int'(req_sample_index) >= int'(n_eff);
   assign g_a       = three_d_ff ? GM2_DEC : GA2D_DEC;
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   gakc_frac #(.ANGLE_BITS(ANGLE_BITS)) u_frac_a (
      .clock (clock),
      .en    (en),
      .g     (g_a),
      .spoke (req_spoke_index),
      .frac  (frac_a)
   );

   gakc_frac #(.ANGLE_BITS(ANGLE_BITS)) u_frac_b (
      .clock (clock),
      .en    (en),
      .g     (GM1_DEC),
      .spoke (req_spoke_index),
      .frac  (frac_b)
   );

   gakc_radius u_radius (
      .clock  (clock),
      .en     (en),
      .sample (req_sample_index),
      .n      (n_eff),
      .quo    (quo),
      .neg    (neg)
   );

   assign r_div = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   gakc_delay #(.WIDTH(RADIUS_W), .DEPTH(LF + 2)) u_r_dly (
      .clock (clock),
      .en    (en),
      .d     (r_div),
      .q     (r_a)
   );

   gakc_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock (clock),
      .en    (en),
      .angle (frac_a),
      .cos_o (cos_c),
      .sin_o (sin_c)
   );

   gakc_delay #(.WIDTH(2 * CORDIC_W), .DEPTH(3)) u_cs_dly (
      .clock (clock),
      .en    (en),
      .d     ({cos_c, sin_c}),
      .q     (cs_d)
   );

   assign c_d = cs_d[2*CORDIC_W-1:CORDIC_W];
   assign s_d = cs_d[CORDIC_W-1:0];

   assign a32b = 32'(frac_b) << (32 - ANGLE_BITS);
   assign f31  = a32b[31:1];

   gakc_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .f31   (f31),
      .root  (root)
   );

   gakc_delay #(.WIDTH(31), .DEPTH(18)) u_f_dly (
      .clock (clock),
      .en    (en),
      .d     (f31),
      .q     (f31_d)
   );

   gakc_delay #(.WIDTH(1), .DEPTH(LF + 19)) u_err_dly (
      .clock (clock),
      .en    (en),
      .d     (err_now),
      .q     (err_d)
   );

   assign root_s  = $signed({1'b0, root});
   assign rt_prod = r_a * root_s;
   assign rt_sh   = rt_prod >>> 31;
   assign m       = three_d_ff ? t_ff : {r_b_ff[RADIUS_W-1], r_b_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff   <= rt_sh[31:0];
         r_b_ff <= r_a;
         px_ff  <= m * c_d;
         py_ff  <= m * s_d;
         pz_ff  <= r_b_ff * $signed({1'b0, f31_d});
         err_ff <= err_d;
         if (err_d) begin
            x_ff <= '0;
            y_ff <= '0;
            z_ff <= '0;
         end else begin
            x_ff <= round_sat(px_ff, XS);
            y_ff <= round_sat(py_ff, XS);
            z_ff <= three_d_ff ? round_sat(pz_ff, ZS) : '0;
         end
      end
   end

   assign rsp_coord_x     = x_ff;
   assign rsp_coord_y     = y_ff;
   assign rsp_coord_z     = z_ff;
   assign rsp_index_error = err_ff;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |->
         (rsp_coord_x == '0) && (rsp_coord_y == '0) && (rsp_coord_z == '0))
      else $error("index error beat carries a non-zero coordinate");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-1] && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved while the result beat was stalled");
`endif

endmodule
